// ===== sv/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the sorted table search and delete
// Holds the operation codes, the request and result structs and the compare
// flags that pass between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int DEPTH_DEFAULT = 256;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
	} sts_req_t;

	typedef struct packed {
		logic       found;
		logic [7:0] position;
		logic [8:0] entry_total;
		logic       table_full;
	} sts_res_t;

	// Outcome of comparing a stored key with the request key.
	typedef struct packed {
		logic eq;
		logic lt;
		logic gt;
	} sts_cmp_t;

endpackage

// ===== sv/sts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_ram: key store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic signed [31:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic signed [31:0]         rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sts_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_cmp: shared key comparator
// Compares a stored key against the request key as signed numbers.
// ----------------------------------------------------------------------------
module sts_cmp
	import sts_pkg::*;
(
	input  logic signed [31:0] stored,
	input  logic signed [31:0] key,
	output sts_cmp_t           cmp
);

	always_comb begin
		cmp.eq = (stored == key);
		cmp.lt = (stored < key);
		cmp.gt = (stored > key);
	end

endmodule

// ===== sv/sts_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_seq: operation sequencer
// Walks the key store one entry per step for insert and delete, and runs the
// binary search probes, all through the single comparator and the store's read and write ports.
// ----------------------------------------------------------------------------
module sts_seq
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  sts_req_t                  request,
	output logic                      done,
	output sts_res_t                  result,
	input  sts_cmp_t                  cmp,
	output logic signed [31:0]        key,
	input  logic signed [31:0]        rdata,
	output logic                      we,
	output logic [$clog2(DEPTH)-1:0]  waddr,
	output logic signed [31:0]        wdata,
	output logic [$clog2(DEPTH)-1:0]  raddr
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] TWO  = CW'(2);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_INS_CMP   = 3'd1;
	localparam logic [2:0] ST_INS_PUT   = 3'd2;
	localparam logic [2:0] ST_SRCH_RD   = 3'd3;
	localparam logic [2:0] ST_SRCH_CMP  = 3'd4;
	localparam logic [2:0] ST_DEL_SCAN  = 3'd5;
	localparam logic [2:0] ST_DEL_SHIFT = 3'd6;

	logic [2:0]         state_q;
	logic signed [31:0] key_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      pos_q;
	logic               done_q;
	sts_res_t           res_q;

	logic [CW-1:0] mid;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] wr_addr;

	function automatic sts_res_t make_res(input logic f, input logic [CW-1:0] p,
		input logic [CW-1:0] t, input logic full);
		sts_res_t r;
		r.found       = f;
		r.position    = 8'(p);
		r.entry_total = 9'(t);
		r.table_full  = full;
		return r;
	endfunction

	assign mid   = lo_q + ((hi_q - lo_q - ONE) >> 1);
	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign result = res_q;
	assign key   = key_q;
	assign raddr = rd_addr[IW-1:0];
	assign waddr = wr_addr[IW-1:0];

	// The read address is set in the cycle before its data is used; in idle
	// it already points at the first entry an insert or delete will need.
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = idx_q;
		wdata   = key_q;
		case (state_q)
			ST_IDLE: begin
				if (request.operation == OP_INSERT) begin
					rd_addr = cnt_q - ONE;
				end
			end
			ST_INS_CMP: begin
				rd_addr = idx_q - TWO;
				if (cmp.gt) begin
					we    = 1'b1;
					wdata = rdata;
				end
			end
			ST_INS_PUT: begin
				we = 1'b1;
			end
			ST_SRCH_RD: begin
				rd_addr = mid;
			end
			ST_DEL_SCAN: begin
				rd_addr = idx_q + ONE;
			end
			ST_DEL_SHIFT: begin
				rd_addr = idx_q + TWO;
				if ((idx_q + ONE) < cnt_q) begin
					we    = 1'b1;
					wdata = rdata;
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q <= request.value;
						case (request.operation)
							OP_INSERT: begin
								if (cnt_q == FULL) begin
									res_q  <= make_res(1'b0, '0, cnt_q, 1'b1);
									done_q <= 1'b1;
								end else if (cnt_q == '0) begin
									idx_q   <= '0;
									state_q <= ST_INS_PUT;
								end else begin
									idx_q   <= cnt_q;
									state_q <= ST_INS_CMP;
								end
							end
							OP_SEARCH: begin
								lo_q    <= '0;
								hi_q    <= cnt_q;
								state_q <= ST_SRCH_RD;
							end
							OP_DELETE: begin
								if (cnt_q == '0) begin
									res_q  <= make_res(1'b0, '0, cnt_q, 1'b0);
									done_q <= 1'b1;
								end else begin
									idx_q   <= '0;
									state_q <= ST_DEL_SCAN;
								end
							end
							default: begin
								res_q  <= make_res(1'b0, '0, cnt_q, 1'b0);
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_INS_CMP: begin
					// Larger keys move up one place; the first key not larger
					// marks where the new key goes.
					if (cmp.gt) begin
						idx_q <= idx_q - ONE;
						if (idx_q == ONE) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						state_q <= ST_INS_PUT;
					end
				end
				ST_INS_PUT: begin
					cnt_q   <= cnt_q + ONE;
					res_q   <= make_res(1'b0, idx_q, cnt_q + ONE, 1'b0);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SRCH_RD: begin
					if (lo_q >= hi_q) begin
						res_q   <= make_res(1'b0, '0, cnt_q, 1'b0);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= mid;
						state_q <= ST_SRCH_CMP;
					end
				end
				ST_SRCH_CMP: begin
					if (cmp.eq) begin
						res_q   <= make_res(1'b1, idx_q, cnt_q, 1'b0);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (cmp.lt) begin
							lo_q <= idx_q + ONE;
						end else begin
							hi_q <= idx_q;
						end
						state_q <= ST_SRCH_RD;
					end
				end
				ST_DEL_SCAN: begin
					if (cmp.eq) begin
						pos_q   <= idx_q;
						state_q <= ST_DEL_SHIFT;
					end else if ((idx_q + ONE) >= cnt_q) begin
						res_q   <= make_res(1'b0, '0, cnt_q, 1'b0);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + ONE;
					end
				end
				ST_DEL_SHIFT: begin
					if ((idx_q + ONE) < cnt_q) begin
						idx_q <= idx_q + ONE;
					end else begin
						cnt_q   <= cnt_q - ONE;
						res_q   <= make_res(1'b1, pos_q, cnt_q - ONE, 1'b0);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sorted_table_search_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_delete: sorted key table with insert, search and delete
// Keeps an ascending table of signed keys and runs one request at a time
// through the key store's read and write ports and a shared comparator.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; the request is taken
// at that clock edge and busy stays high until the work is finished. The
// result appears on result for exactly one cycle with done high; it must be
// taken then, as the block cannot be held off.
// Steps of each request:
//   insert: larger stored keys move up from the top, one key moved per cycle;
//   search: each probe reads a stored key and then compares it;
//   delete: the scan and then the shift pass each entry once, one entry per
//     cycle.
// A full-table insert, an empty-table delete or an unused code answer in the
// cycle after the request, and busy does not rise for them.
// A new request may be given in the same cycle as done.
// Reset clears the entry count, so the table starts empty; the key store
// itself is not cleared, as entries at or above the count are never used.
// ----------------------------------------------------------------------------
module sorted_table_search_delete
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sts_req_t request,
	output logic     done,
	output sts_res_t result
);

	localparam int IW = $clog2(DEPTH);

	sts_cmp_t           cmp;
	logic signed [31:0] key;
	logic signed [31:0] rdata;
	logic               we;
	logic [IW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [IW-1:0]      raddr;

	sts_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result),
		.cmp    (cmp),
		.key    (key),
		.rdata  (rdata),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr)
	);

	sts_cmp u_cmp (
		.stored(rdata),
		.key   (key),
		.cmp   (cmp)
	);

	sts_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted table search and delete block
// Drives insert, search, delete and unused requests through the start/busy
// handshake, predicts every result from a behavioural copy of the sorted
// table, and compares each done strobe field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench
	import sts_pkg::*;
();

	localparam int         TABLE_DEPTH    = DEPTH_DEFAULT;
	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         TAIL_CYCLES    = 600;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	sts_req_t request;
	logic     done;
	sts_res_t result;

	// Behavioural copy of the table, advanced as each request is taken.
	logic signed [31:0] key_model [TABLE_DEPTH];
	int                 model_count;
	sts_res_t           pending [$];

	int          send_gap_pct;
	int unsigned requests_taken;
	int          idle_cycles;
	int          mismatches;
	int          op_tally [4];
	int          refused_inserts;
	int          search_hits;
	int          delete_hits;
	int          peak_fill;

	sorted_table_search_delete DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Updates the table copy for one request and returns the result it should give.
	function automatic sts_res_t apply_to_table(input sts_req_t req);
		sts_res_t res;
		int       slot;
		int       i;
		int       lo;
		int       hi;
		int       mid;
		res = '0;
		res.entry_total = 9'(model_count);
		case (req.operation)
			OP_INSERT: begin
				if (model_count >= TABLE_DEPTH) begin
					res.table_full = 1'b1;
				end else begin
					slot = 0;
					while (slot < model_count && key_model[slot] <= req.value)
						slot++;
					for (i = model_count; i > slot; i--)
						key_model[i] = key_model[i - 1];
					key_model[slot] = req.value;
					model_count++;
					res.position    = 8'(slot);
					res.entry_total = 9'(model_count);
				end
			end
			OP_SEARCH: begin
				lo = 0;
				hi = model_count - 1;
				while (lo <= hi && !res.found) begin
					mid = lo + (hi - lo) / 2;
					if (key_model[mid] == req.value) begin
						res.found    = 1'b1;
						res.position = 8'(mid);
					end else if (key_model[mid] < req.value) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			OP_DELETE: begin
				slot = -1;
				for (i = 0; i < model_count && slot < 0; i++)
					if (key_model[i] == req.value)
						slot = i;
				if (slot >= 0) begin
					for (i = slot; i + 1 < model_count; i++)
						key_model[i] = key_model[i + 1];
					model_count--;
					res.found       = 1'b1;
					res.position    = 8'(slot);
					res.entry_total = 9'(model_count);
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Results are checked before the request of the same edge is predicted, so
	// a request taken in the cycle of a done strobe queues behind it.
	always @(posedge clk) begin
		sts_res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = pending.pop_front();
					if (result.found !== want.found)
						report_mismatch("found", result.found, want.found);
					if (result.position !== want.position)
						report_mismatch("position", result.position, want.position);
					if (result.entry_total !== want.entry_total)
						report_mismatch("entry_total", result.entry_total, want.entry_total);
					if (result.table_full !== want.table_full)
						report_mismatch("table_full", result.table_full, want.table_full);
				end
			end
			if (start && !busy) begin
				want = apply_to_table(request);
				pending.push_back(want);
				requests_taken++;
				op_tally[request.operation]++;
				if (want.table_full)
					refused_inserts++;
				if (want.found && request.operation == OP_SEARCH)
					search_hits++;
				if (want.found && request.operation == OP_DELETE)
					delete_hits++;
				if (model_count > peak_fill)
					peak_fill = model_count;
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [1:0] op, input logic signed [31:0] key);
		int unsigned taken;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start             <= 1'b1;
		request.operation <= op;
		request.value     <= key;
		taken = requests_taken;
		wait (requests_taken != taken);
		@(negedge clk);
	endtask

	// Keys mostly from a narrow band or already stored, so that hits and
	// duplicates are common; the rest are extremes or fully random.
	function automatic logic signed [31:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return 32'($signed($urandom_range(16)) - 8);
		if (r < 70 && model_count > 0)
			return key_model[$urandom_range(model_count - 1)];
		if (r < 80) begin
			case ($urandom_range(5))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh8000_0001;
				3: return 32'sh7fff_fffe;
				4: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return 32'($urandom);
	endfunction

	task automatic test_directed_cases();
		send_gap_pct = 19;
		// Empty table: every lookup is a miss.
		send_request(OP_SEARCH, 32'sd5);
		send_request(OP_DELETE, 32'sd5);
		send_request(OP_UNUSED, 32'sd5);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, -32'sd1);
		send_request(OP_INSERT, 32'sd1);
		send_request(OP_SEARCH, 32'sh8000_0000);
		send_request(OP_SEARCH, 32'sh7fff_ffff);
		// Repeated key: the first probe that matches wins, not the lowest index.
		send_request(OP_SEARCH, 32'sd0);
		send_request(OP_SEARCH, 32'sd2);
		send_request(OP_UNUSED, -32'sd1);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DELETE, 32'sd12345);
		send_request(OP_DELETE, 32'sh8000_0000);
		send_request(OP_DELETE, 32'sh7fff_ffff);
		send_request(OP_SEARCH, -32'sd1);
		send_request(OP_INSERT, 32'sh5555_5555);
		send_request(OP_INSERT, 32'shaaaa_aaaa);
		send_request(OP_SEARCH, 32'shaaaa_aaaa);
	endtask

	// Fills the table to capacity, checks refusals at full, then empties it.
	task automatic test_full_table();
		int k;
		send_gap_pct = 19;
		while (model_count < TABLE_DEPTH)
			send_request(OP_INSERT, pick_key());
		for (k = 0; k < 3; k++)
			send_request(OP_INSERT, pick_key());
		for (k = 0; k < 20; k++)
			send_request(OP_SEARCH, pick_key());
		while (model_count > 0) begin
			if ($urandom_range(9) == 0)
				send_request(OP_DELETE, 32'($urandom));
			else
				send_request(OP_DELETE, key_model[$urandom_range(model_count - 1)]);
		end
		send_request(OP_DELETE, pick_key());
		send_request(OP_SEARCH, pick_key());
	endtask

	task automatic test_random_traffic(input int gap_pct, input int items);
		int          k;
		int unsigned r;
		logic [1:0]  op;
		send_gap_pct = gap_pct;
		for (k = 0; k < items; k++) begin
			r = $urandom_range(99);
			if (r < 40)
				op = OP_INSERT;
			else if (r < 68)
				op = OP_SEARCH;
			else if (r < 94)
				op = OP_DELETE;
			else
				op = OP_UNUSED;
			send_request(op, pick_key());
		end
	endtask

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("[%0t] no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		request      = '0;
		model_count  = 0;
		send_gap_pct = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_full_table();
		test_random_traffic(19, 200);
		test_random_traffic(69, 300);
		test_random_traffic(0, 400);

		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d inserts, %0d searches, %0d deletes, %0d unused codes.",
			requests_taken, op_tally[OP_INSERT], op_tally[OP_SEARCH], op_tally[OP_DELETE],
			op_tally[OP_UNUSED]);
		$display("Table peaked at %0d keys; %0d inserts refused, %0d search and %0d delete hits.",
			peak_fill, refused_inserts, search_hits, delete_hits);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
